// File: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define CTB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define CTB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/ctb_pkg.sv
package ctb_pkg;

	localparam int MAX_RECORDS = 1024;
	localparam int MAX_CATS    = 64;

	localparam int RA_W = $clog2(MAX_RECORDS);
	localparam int RT_W = RA_W + 1;
	localparam int CI_W = $clog2(MAX_CATS);
	localparam int CL_W = CI_W + 1;
	localparam int GA_W = 2 * CI_W;
	localparam int GRID_DEPTH = MAX_CATS * MAX_CATS;

	localparam int CAT_W   = 32;
	localparam int TALLY_W = 40;
	localparam int AREA_W  = 64;
	localparam int REC_W   = 2 * CAT_W + TALLY_W + AREA_W;
	localparam int CELL_W  = TALLY_W + AREA_W;

	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_BUILD = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;
	localparam logic [1:0] REQ_CLEAR = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_TOO_MANY  = 3'd2;
	localparam logic [2:0] ST_RANGE     = 3'd3;
	localparam logic [2:0] ST_NOT_BUILT = 3'd4;

	typedef struct packed {
		logic full;
		logic built;
		logic range_bad;
		logic total_zero;
		logic scan_last;
		logic sweep_last;
		logic found_any;
		logic overflow;
		logic out_free;
	} ctb_sts_t;

	typedef struct packed {
		logic       rec_load;
		logic       clr_all;
		logic       build_init;
		logic       pass_init;
		logic       scan_step;
		logic       pass_close;
		logic       fail;
		logic       sweep_init;
		logic       sweep_step;
		logic       fill_step;
		logic       finish;
		logic       read_issue;
		logic       out_load;
		logic       out_is_read;
		logic [2:0] out_status;
	} ctb_cmd_t;

endpackage

// File: design/ctb_ram.sv
module ctb_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/ctb_ctrl.sv
module ctb_ctrl import ctb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] req_type,
	input  ctb_sts_t   sts,
	output ctb_cmd_t   cmd
);

	localparam logic [3:0] S_IDLE       = 4'd0;
	localparam logic [3:0] S_PASS_START = 4'd1;
	localparam logic [3:0] S_SCAN       = 4'd2;
	localparam logic [3:0] S_PASS_DRAIN = 4'd3;
	localparam logic [3:0] S_PASS_END   = 4'd4;
	localparam logic [3:0] S_SWEEP      = 4'd5;
	localparam logic [3:0] S_FILL       = 4'd6;
	localparam logic [3:0] S_FILL_D1    = 4'd7;
	localparam logic [3:0] S_FILL_D2    = 4'd8;
	localparam logic [3:0] S_FINISH     = 4'd9;
	localparam logic [3:0] S_RESP       = 4'd10;

	logic [3:0] state_q, state_d;
	logic [2:0] st_q, st_d;
	logic       rd_q, rd_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		st_d    = st_q;
		rd_d    = rd_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					rd_d    = 1'b0;
					st_d    = ST_OK;
					state_d = S_RESP;
					case (req_type)
						REQ_LOAD: begin
							cmd.rec_load = !sts.full;
							st_d = sts.full ? ST_FULL : ST_OK;
						end
						REQ_BUILD: begin
							cmd.build_init = 1'b1;
							state_d = S_PASS_START;
						end
						REQ_READ: begin
							cmd.read_issue = 1'b1;
							rd_d = 1'b1;
							if (!sts.built) begin
								st_d = ST_NOT_BUILT;
							end else if (sts.range_bad) begin
								st_d = ST_RANGE;
							end
						end
						REQ_CLEAR: begin
							cmd.clr_all = 1'b1;
						end
						default: begin
							cmd.clr_all = 1'b1;
						end
					endcase
				end
			end
			S_PASS_START: begin
				cmd.pass_init = 1'b1;
				state_d = sts.total_zero ? S_PASS_DRAIN : S_SCAN;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = S_PASS_DRAIN;
				end
			end
			S_PASS_DRAIN: begin
				state_d = S_PASS_END;
			end
			S_PASS_END: begin
				if (sts.overflow) begin
					cmd.fail = 1'b1;
					st_d     = ST_TOO_MANY;
					state_d  = S_RESP;
				end else if (sts.found_any) begin
					cmd.pass_close = 1'b1;
					state_d = S_PASS_START;
				end else begin
					cmd.sweep_init = 1'b1;
					state_d = S_SWEEP;
				end
			end
			S_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (sts.sweep_last) begin
					state_d = sts.total_zero ? S_FINISH : S_FILL;
				end
			end
			S_FILL: begin
				cmd.fill_step = 1'b1;
				if (sts.scan_last) begin
					state_d = S_FILL_D1;
				end
			end
			S_FILL_D1: begin
				state_d = S_FILL_D2;
			end
			S_FILL_D2: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				st_d    = ST_OK;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.out_load    = 1'b1;
					cmd.out_status  = st_q;
					cmd.out_is_read = rd_q;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= ST_OK;
			rd_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			rd_q    <= rd_d;
		end
	end

endmodule

// File: design/ctb_dp.sv
`include "assert_macros.svh"

module ctb_dp import ctb_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ctb_cmd_t                  cmd,
	output ctb_sts_t                  sts,
	input  logic signed [CAT_W-1:0]   cat_first,
	input  logic signed [CAT_W-1:0]   cat_second,
	input  logic [TALLY_W-1:0]        cell_tally,
	input  logic [AREA_W-1:0]         area_word,
	input  logic [CI_W-1:0]           col_index,
	input  logic [CI_W-1:0]           row_index,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [2:0]                status,
	output logic [CL_W-1:0]           cats_across,
	output logic [CL_W-1:0]           cats_down,
	output logic                      swapped,
	output logic signed [CL_W-1:0]    nodata_across,
	output logic signed [CL_W-1:0]    nodata_down,
	output logic [TALLY_W-1:0]        cell_count,
	output logic [AREA_W-1:0]         cell_area,
	output logic signed [CAT_W-1:0]   across_value,
	output logic signed [CAT_W-1:0]   down_value
);

	// committed table state
	logic [RT_W-1:0] rec_total_q;
	logic [CL_W-1:0] cats_across_q, cats_down_q;
	logic [CL_W-1:0] hole_across_q, hole_down_q;
	logic            swap_q, built_q;

	// build working state
	logic [CL_W-1:0]         na_q, nb_q, ha_q, hb_q;
	logic signed [CAT_W-1:0] prev_a_q, prev_b_q, best_a_q, best_b_q;
	logic                    hp_q, fa_q, fb_q;
	logic [RA_W-1:0]         scan_q;
	logic [GA_W-1:0]         gaddr_q;
	logic                    v_s1, fv_s1, fv_s2;
	logic [RA_W-1:0]         r_s1;
	logic [GA_W-1:0]         k_s2;
	logic [CELL_W-1:0]       gd_s2;

	logic                    out_valid_q;
	logic [2:0]              out_st_q;
	logic [CL_W-1:0]         out_ca_q, out_cd_q, out_ha_q, out_hd_q;
	logic                    out_swp_q;
	logic [TALLY_W-1:0]      out_cnt_q;
	logic [AREA_W-1:0]       out_area_q;
	logic [CAT_W-1:0]        out_av_q, out_dv_q;

	logic [REC_W-1:0]        rec_rd;
	logic [CI_W-1:0]         rank_a_rd, rank_b_rd;
	logic [CAT_W-1:0]        la_rd, lb_rd;
	logic [CELL_W-1:0]       grid_rd;

	logic signed [CAT_W-1:0] ca, cb;
	logic                    swap_w;
	logic [CL_W-1:0]         len_a_w;
	logic [CI_W-1:0]         csel, dsel;
	logic [CI_W+CL_W-1:0]    fill_prod, read_prod;
	logic                    rank_a_we, rank_b_we;
	logic                    grid_we;
	logic [GA_W-1:0]         grid_waddr, grid_raddr;
	logic [CELL_W-1:0]       grid_wdata;
	logic                    good_read;

	assign ca      = rec_rd[REC_W-1 -: CAT_W];
	assign cb      = rec_rd[REC_W-CAT_W-1 -: CAT_W];
	assign swap_w  = (na_q > nb_q);
	assign len_a_w = swap_w ? nb_q : na_q;
	assign csel    = swap_w ? rank_b_rd : rank_a_rd;
	assign dsel    = swap_w ? rank_a_rd : rank_b_rd;
	assign fill_prod = dsel * len_a_w;
	assign read_prod = row_index * cats_across_q;
	assign grid_raddr = GA_W'(read_prod + (CI_W+CL_W)'(col_index));

	assign rank_a_we = v_s1 && hp_q && (ca == prev_a_q);
	assign rank_b_we = v_s1 && hp_q && (cb == prev_b_q);

	assign grid_we    = cmd.sweep_step || fv_s2;
	assign grid_waddr = cmd.sweep_step ? gaddr_q : k_s2;
	assign grid_wdata = cmd.sweep_step ? '0 : gd_s2;

	ctb_ram #(.W(REC_W), .D(MAX_RECORDS)) u_rec (
		.clk   (clk),
		.we    (cmd.rec_load),
		.waddr (rec_total_q[RA_W-1:0]),
		.wdata ({cat_first, cat_second, cell_tally, area_word}),
		.re    (cmd.scan_step || cmd.fill_step),
		.raddr (scan_q),
		.rdata (rec_rd)
	);

	ctb_ram #(.W(CI_W), .D(MAX_RECORDS)) u_rank_a (
		.clk   (clk),
		.we    (rank_a_we),
		.waddr (r_s1),
		.wdata (CI_W'(na_q - CL_W'(1))),
		.re    (cmd.fill_step),
		.raddr (scan_q),
		.rdata (rank_a_rd)
	);

	ctb_ram #(.W(CI_W), .D(MAX_RECORDS)) u_rank_b (
		.clk   (clk),
		.we    (rank_b_we),
		.waddr (r_s1),
		.wdata (CI_W'(nb_q - CL_W'(1))),
		.re    (cmd.fill_step),
		.raddr (scan_q),
		.rdata (rank_b_rd)
	);

	ctb_ram #(.W(CAT_W), .D(MAX_CATS)) u_list_a (
		.clk   (clk),
		.we    (cmd.pass_close && fa_q),
		.waddr (na_q[CI_W-1:0]),
		.wdata (best_a_q),
		.re    (cmd.read_issue),
		.raddr (swap_q ? row_index : col_index),
		.rdata (la_rd)
	);

	ctb_ram #(.W(CAT_W), .D(MAX_CATS)) u_list_b (
		.clk   (clk),
		.we    (cmd.pass_close && fb_q),
		.waddr (nb_q[CI_W-1:0]),
		.wdata (best_b_q),
		.re    (cmd.read_issue),
		.raddr (swap_q ? col_index : row_index),
		.rdata (lb_rd)
	);

	ctb_ram #(.W(CELL_W), .D(GRID_DEPTH)) u_grid (
		.clk   (clk),
		.we    (grid_we),
		.waddr (grid_waddr),
		.wdata (grid_wdata),
		.re    (cmd.read_issue),
		.raddr (grid_raddr),
		.rdata (grid_rd)
	);

	always_comb begin
		sts.full       = (rec_total_q == RT_W'(MAX_RECORDS));
		sts.built      = built_q;
		sts.range_bad  = ({1'b0, col_index} >= cats_across_q) ||
		                 ({1'b0, row_index} >= cats_down_q);
		sts.total_zero = (rec_total_q == '0);
		sts.scan_last  = ({1'b0, scan_q} == rec_total_q - RT_W'(1));
		sts.sweep_last = (gaddr_q == GA_W'(GRID_DEPTH - 1));
		sts.found_any  = fa_q || fb_q;
		sts.overflow   = (fa_q && (na_q == CL_W'(MAX_CATS))) ||
		                 (fb_q && (nb_q == CL_W'(MAX_CATS)));
		sts.out_free   = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_total_q   <= '0;
			cats_across_q <= '0;
			cats_down_q   <= '0;
			hole_across_q <= '1;
			hole_down_q   <= '1;
			swap_q        <= 1'b0;
			built_q       <= 1'b0;
			na_q          <= '0;
			nb_q          <= '0;
			ha_q          <= '1;
			hb_q          <= '1;
			hp_q          <= 1'b0;
			fa_q          <= 1'b0;
			fb_q          <= 1'b0;
			scan_q        <= '0;
			gaddr_q       <= '0;
			v_s1          <= 1'b0;
			fv_s1         <= 1'b0;
			fv_s2         <= 1'b0;
			out_valid_q   <= 1'b0;
			out_st_q      <= ST_OK;
		end else begin
			v_s1  <= cmd.scan_step;
			fv_s1 <= cmd.fill_step;
			fv_s2 <= fv_s1;
			if (cmd.rec_load) begin
				rec_total_q <= rec_total_q + RT_W'(1);
			end
			if (cmd.clr_all || cmd.fail) begin
				cats_across_q <= '0;
				cats_down_q   <= '0;
				hole_across_q <= '1;
				hole_down_q   <= '1;
				swap_q        <= 1'b0;
				built_q       <= 1'b0;
			end
			if (cmd.clr_all) begin
				rec_total_q <= '0;
			end
			if (cmd.build_init) begin
				na_q <= '0;
				nb_q <= '0;
				ha_q <= '1;
				hb_q <= '1;
				hp_q <= 1'b0;
			end
			if (cmd.pass_init) begin
				fa_q   <= 1'b0;
				fb_q   <= 1'b0;
				scan_q <= '0;
			end
			if (cmd.scan_step || cmd.fill_step) begin
				scan_q <= scan_q + RA_W'(1);
			end
			if (v_s1) begin
				if ((!hp_q || ca > prev_a_q) && (!fa_q || ca < best_a_q)) begin
					fa_q <= 1'b1;
				end
				if ((!hp_q || cb > prev_b_q) && (!fb_q || cb < best_b_q)) begin
					fb_q <= 1'b1;
				end
			end
			if (cmd.pass_close) begin
				hp_q <= 1'b1;
				if (fa_q) begin
					na_q <= na_q + CL_W'(1);
					if (best_a_q == '0) begin
						ha_q <= na_q;
					end
				end
				if (fb_q) begin
					nb_q <= nb_q + CL_W'(1);
					if (best_b_q == '0) begin
						hb_q <= nb_q;
					end
				end
			end
			if (cmd.sweep_init) begin
				gaddr_q <= '0;
				scan_q  <= '0;
			end
			if (cmd.sweep_step) begin
				gaddr_q <= gaddr_q + GA_W'(1);
			end
			if (cmd.finish) begin
				built_q       <= 1'b1;
				swap_q        <= swap_w;
				cats_across_q <= swap_w ? nb_q : na_q;
				cats_down_q   <= swap_w ? na_q : nb_q;
				hole_across_q <= swap_w ? hb_q : ha_q;
				hole_down_q   <= swap_w ? ha_q : hb_q;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
				out_st_q    <= cmd.out_status;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign good_read = cmd.out_is_read && (cmd.out_status == ST_OK);

	// payload registers
	always_ff @(posedge clk) begin
		r_s1 <= scan_q;
		if (v_s1) begin
			if ((!hp_q || ca > prev_a_q) && (!fa_q || ca < best_a_q)) begin
				best_a_q <= ca;
			end
			if ((!hp_q || cb > prev_b_q) && (!fb_q || cb < best_b_q)) begin
				best_b_q <= cb;
			end
		end
		if (cmd.pass_close) begin
			if (fa_q) begin
				prev_a_q <= best_a_q;
			end
			if (fb_q) begin
				prev_b_q <= best_b_q;
			end
		end
		k_s2  <= GA_W'(fill_prod + (CI_W+CL_W)'(csel));
		gd_s2 <= rec_rd[CELL_W-1:0];
		if (cmd.out_load) begin
			out_ca_q   <= cats_across_q;
			out_cd_q   <= cats_down_q;
			out_swp_q  <= swap_q;
			out_ha_q   <= hole_across_q;
			out_hd_q   <= hole_down_q;
			out_cnt_q  <= good_read ? grid_rd[CELL_W-1 -: TALLY_W] : '0;
			out_area_q <= good_read ? grid_rd[AREA_W-1:0] : '0;
			out_av_q   <= good_read ? (swap_q ? lb_rd : la_rd) : '0;
			out_dv_q   <= good_read ? (swap_q ? la_rd : lb_rd) : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_st_q;
	assign cats_across   = out_ca_q;
	assign cats_down     = out_cd_q;
	assign swapped       = out_swp_q;
	assign nodata_across = out_ha_q;
	assign nodata_down   = out_hd_q;
	assign cell_count    = out_cnt_q;
	assign cell_area     = out_area_q;
	assign across_value  = out_av_q;
	assign down_value    = out_dv_q;

	`CTB_ASSERT(a_axis_order, !built_q || (cats_across_q <= cats_down_q), "across list longer than down list")
	`CTB_ASSERT(a_hole_range, !built_q || hole_across_q[CL_W-1] || (hole_across_q < cats_across_q), "nodata position outside across list")
	`CTB_ASSERT(a_total_range, rec_total_q <= RT_W'(MAX_RECORDS), "record count beyond store depth")
	`CTB_ASSERT_NEXT(a_fill_write, fv_s1, grid_we && !cmd.sweep_step, "fill write lost or colliding with sweep")

endmodule

// File: design/coincidence_table_builder.sv
// Cross tabulation of two category maps. Every request (load record, build, read cell,
// clear) returns one result transaction. No new request is taken until the result is
// registered, and the output register lets the next request enter while that result
// waits. A build scans the record store once per distinct category in the longer list
// plus once more, then clears the 4096-entry table one entry per cycle and writes each
// record into it. The single read port of the record memory sets the build time. No
// clearing pass is needed after reset.
module coincidence_table_builder import ctb_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                req_type,
	input  logic signed [CAT_W-1:0]   cat_first,
	input  logic signed [CAT_W-1:0]   cat_second,
	input  logic [TALLY_W-1:0]        cell_tally,
	input  logic [AREA_W-1:0]         area_word,
	input  logic [CI_W-1:0]           col_index,
	input  logic [CI_W-1:0]           row_index,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [2:0]                status,
	output logic [CL_W-1:0]           cats_across,
	output logic [CL_W-1:0]           cats_down,
	output logic                      swapped,
	output logic signed [CL_W-1:0]    nodata_across,
	output logic signed [CL_W-1:0]    nodata_down,
	output logic [TALLY_W-1:0]        cell_count,
	output logic [AREA_W-1:0]         cell_area,
	output logic signed [CAT_W-1:0]   across_value,
	output logic signed [CAT_W-1:0]   down_value
);

	ctb_cmd_t cmd;
	ctb_sts_t sts;

	ctb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_type (req_type),
		.sts      (sts),
		.cmd      (cmd)
	);

	ctb_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cat_first     (cat_first),
		.cat_second    (cat_second),
		.cell_tally    (cell_tally),
		.area_word     (area_word),
		.col_index     (col_index),
		.row_index     (row_index),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.cats_across   (cats_across),
		.cats_down     (cats_down),
		.swapped       (swapped),
		.nodata_across (nodata_across),
		.nodata_down   (nodata_down),
		.cell_count    (cell_count),
		.cell_area     (cell_area),
		.across_value  (across_value),
		.down_value    (down_value)
	);

endmodule

// File: tb/ctb_checker.sv
module ctb_checker import ctb_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_stall,
	input  logic [1:0]              req_type,
	input  logic signed [CAT_W-1:0] cat_first,
	input  logic signed [CAT_W-1:0] cat_second,
	input  logic [TALLY_W-1:0]      cell_tally,
	input  logic [AREA_W-1:0]       area_word,
	input  logic [CI_W-1:0]         col_index,
	input  logic [CI_W-1:0]         row_index,
	input  logic                    out_valid,
	input  logic                    out_stall,
	input  logic [2:0]              status,
	input  logic [CL_W-1:0]         cats_across,
	input  logic [CL_W-1:0]         cats_down,
	input  logic                    swapped,
	input  logic signed [CL_W-1:0]  nodata_across,
	input  logic signed [CL_W-1:0]  nodata_down,
	input  logic [TALLY_W-1:0]      cell_count,
	input  logic [AREA_W-1:0]       cell_area,
	input  logic signed [CAT_W-1:0] across_value,
	input  logic signed [CAT_W-1:0] down_value,
	output int                      errors,
	output int                      pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0]         status;
		logic [CL_W-1:0]    across_len;
		logic [CL_W-1:0]    down_len;
		logic               swp;
		logic [CL_W-1:0]    hole_ac;
		logic [CL_W-1:0]    hole_dn;
		logic [TALLY_W-1:0] count;
		logic [AREA_W-1:0]  area;
		logic [CAT_W-1:0]   av;
		logic [CAT_W-1:0]   dv;
	} cell_reply_t;

	cell_reply_t replies[$];

	logic signed [CAT_W-1:0] rec_a[MAX_RECORDS];
	logic signed [CAT_W-1:0] rec_b[MAX_RECORDS];
	logic [TALLY_W-1:0]      rec_tally[MAX_RECORDS];
	logic [AREA_W-1:0]       rec_area[MAX_RECORDS];
	int                      n_rec;

	// index 0 is the across axis, 1 the down axis
	logic signed [CAT_W-1:0] axis[2][MAX_CATS];
	int                      axis_len[2];
	logic signed [CAT_W-1:0] work[2][MAX_CATS];
	int                      work_len[2];
	logic [TALLY_W-1:0]      grid_cnt[GRID_DEPTH];
	logic [AREA_W-1:0]       grid_ar[GRID_DEPTH];
	bit                      swp;
	bit                      built;
	int                      hole[2];

	function automatic void reset_table();
		axis_len[0] = 0;
		axis_len[1] = 0;
		swp = 0;
		hole[0] = -1;
		hole[1] = -1;
		built = 0;
	endfunction

	function automatic bit place_cat(int which, logic signed [CAT_W-1:0] v);
		int i;
		i = 0;
		while (i < work_len[which] && work[which][i] < v)
			i++;
		if (i < work_len[which] && work[which][i] == v)
			return 1;
		if (work_len[which] >= MAX_CATS)
			return 0;
		for (int j = work_len[which]; j > i; j--)
			work[which][j] = work[which][j-1];
		work[which][i] = v;
		work_len[which]++;
		return 1;
	endfunction

	function automatic int locate(int which, logic signed [CAT_W-1:0] v);
		for (int i = 0; i < axis_len[which]; i++)
			if (axis[which][i] == v)
				return i;
		return -1;
	endfunction

	function automatic logic [2:0] build_table();
		int c, d, k;
		logic signed [CAT_W-1:0] ca, cd;
		work_len[0] = 0;
		work_len[1] = 0;
		for (int r = 0; r < n_rec; r++) begin
			if (!place_cat(0, rec_a[r]) || !place_cat(1, rec_b[r])) begin
				reset_table();
				return ST_TOO_MANY;
			end
		end
		swp = work_len[0] > work_len[1];
		for (int i = 0; i < MAX_CATS; i++) begin
			axis[0][i] = swp ? work[1][i] : work[0][i];
			axis[1][i] = swp ? work[0][i] : work[1][i];
		end
		axis_len[0] = swp ? work_len[1] : work_len[0];
		axis_len[1] = swp ? work_len[0] : work_len[1];
		hole[0] = locate(0, 0);
		hole[1] = locate(1, 0);
		for (int i = 0; i < GRID_DEPTH; i++) begin
			grid_cnt[i] = '0;
			grid_ar[i] = '0;
		end
		for (int r = 0; r < n_rec; r++) begin
			ca = swp ? rec_b[r] : rec_a[r];
			cd = swp ? rec_a[r] : rec_b[r];
			c = locate(0, ca);
			d = locate(1, cd);
			if (c >= 0 && d >= 0) begin
				k = d * axis_len[0] + c;
				grid_cnt[k] = rec_tally[r];
				grid_ar[k] = rec_area[r];
			end
		end
		built = 1;
		return ST_OK;
	endfunction

	function automatic cell_reply_t answer();
		cell_reply_t e;
		int c, d, k;
		e = '0;
		e.status = ST_OK;
		case (req_type)
			REQ_LOAD: begin
				if (n_rec >= MAX_RECORDS) begin
					e.status = ST_FULL;
				end else begin
					rec_a[n_rec] = cat_first;
					rec_b[n_rec] = cat_second;
					rec_tally[n_rec] = cell_tally;
					rec_area[n_rec] = area_word;
					n_rec++;
				end
			end
			REQ_BUILD: e.status = build_table();
			REQ_READ: begin
				c = int'(col_index);
				d = int'(row_index);
				if (!built) begin
					e.status = ST_NOT_BUILT;
				end else if (c >= axis_len[0] || d >= axis_len[1]) begin
					e.status = ST_RANGE;
				end else begin
					k = d * axis_len[0] + c;
					e.count = grid_cnt[k];
					e.area = grid_ar[k];
					e.av = axis[0][c];
					e.dv = axis[1][d];
				end
			end
			default: begin
				n_rec = 0;
				reset_table();
			end
		endcase
		e.across_len = CL_W'(axis_len[0]);
		e.down_len = CL_W'(axis_len[1]);
		e.swp = swp;
		e.hole_ac = CL_W'(hole[0]);
		e.hole_dn = CL_W'(hole[1]);
		return e;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		cell_reply_t e;
		if (!arst_n) begin
			n_rec = 0;
			reset_table();
			replies.delete();
			errors = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (replies.size() == 0) begin
					errors++;
					$display("%0t: unexpected result transaction, status %0d", $time, status);
				end else begin
					e = replies.pop_front();
					check_field("status", 64'(e.status), 64'(status));
					check_field("cats_across", 64'(e.across_len), 64'(cats_across));
					check_field("cats_down", 64'(e.down_len), 64'(cats_down));
					check_field("swapped", 64'(e.swp), 64'(swapped));
					check_field("nodata_across", 64'(e.hole_ac),
						64'($unsigned(nodata_across)));
					check_field("nodata_down", 64'(e.hole_dn),
						64'($unsigned(nodata_down)));
					check_field("cell_count", 64'(e.count), 64'(cell_count));
					check_field("cell_area", e.area, cell_area);
					check_field("across_value", 64'(e.av),
						64'($unsigned(across_value)));
					check_field("down_value", 64'(e.dv), 64'($unsigned(down_value)));
				end
			end
			if (in_valid && !in_stall)
				replies.push_back(answer());
		end
	end

	assign pending = replies.size();

endmodule

// File: tb/tb.sv
module tb;
	import ctb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 2000000;
	localparam logic signed [31:0] CAT_MIN = 32'sh80000000;
	localparam logic signed [31:0] CAT_MAX = 32'sh7fffffff;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [1:0] req_type;
	logic signed [CAT_W-1:0] cat_first, cat_second, across_value, down_value;
	logic [TALLY_W-1:0] cell_tally, cell_count;
	logic [AREA_W-1:0] area_word, cell_area;
	logic [CI_W-1:0] col_index, row_index;
	logic [2:0] status;
	logic [CL_W-1:0] cats_across, cats_down;
	logic signed [CL_W-1:0] nodata_across, nodata_down;
	logic swapped;
	int errors, pending, cycles;
	bit calm, jitter, want_choke;

	always #5 clk = ~clk;

	coincidence_table_builder dut (.*);

	ctb_checker chk (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// result side: random stall bursts, one long hold-off on request
	initial begin
		bit rx_jitter;
		out_stall = 1'b0;
		rx_jitter = 1;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 99) == 0)
				rx_jitter = !rx_jitter;
			if (want_choke) begin
				want_choke = 0;
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!calm && rx_jitter && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send(input logic [1:0] rq, input logic signed [31:0] ca, cb,
			input logic [39:0] t, input logic [63:0] ar, input logic [5:0] ci, ri);
		bit held;
		if (!calm && jitter && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		req_type <= rq;
		cat_first <= ca;
		cat_second <= cb;
		cell_tally <= t;
		area_word <= ar;
		col_index <= ci;
		row_index <= ri;
		in_valid <= 1'b1;
		do begin
			@(negedge clk);
			held = in_stall;
			@(posedge clk);
		end while (held);
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	task automatic put_record(input logic signed [31:0] ca, cb);
		send(REQ_LOAD, ca, cb, 40'(rnd64()), rnd64(), 6'($urandom), 6'($urandom));
	endtask

	task automatic ask_build();
		send(REQ_BUILD, $urandom, $urandom, 40'(rnd64()), rnd64(), 6'($urandom),
			6'($urandom));
	endtask

	task automatic ask_cell(input logic [5:0] ci, ri);
		send(REQ_READ, $urandom, $urandom, 40'(rnd64()), rnd64(), ci, ri);
	endtask

	task automatic wipe_all();
		send(REQ_CLEAR, $urandom, $urandom, 40'(rnd64()), rnd64(), 6'($urandom),
			6'($urandom));
	endtask

	function automatic logic signed [31:0] pick_cat(int spread);
		case ($urandom_range(0, 11))
			0: return 0;
			1: return CAT_MIN;
			2: return CAT_MAX;
			3: return -1;
			4: return $urandom;
			default: return $urandom_range(0, spread) - spread / 2;
		endcase
	endfunction

	task automatic random_reads(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 4) == 0)
				ask_cell(6'($urandom), 6'($urandom));
			else
				ask_cell(6'($urandom_range(0, 10)), 6'($urandom_range(0, 10)));
		end
	endtask

	initial begin
		int sent, spread, n;
		in_valid = 1'b0;
		req_type = REQ_LOAD;
		cat_first = '0;
		cat_second = '0;
		cell_tally = '0;
		area_word = '0;
		col_index = '0;
		row_index = '0;
		jitter = 1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		ask_cell(0, 0);
		ask_build();
		ask_cell(0, 0);
		send(REQ_LOAD, CAT_MIN, CAT_MAX, '1, '1, 0, 0);
		send(REQ_LOAD, 0, 0, '0, '0, 0, 0);
		send(REQ_LOAD, CAT_MAX, 0, 40'h1, 64'h1_000000, 0, 0);
		send(REQ_LOAD, CAT_MIN, CAT_MAX, 40'h55, 64'h0123456789abcdef, 0, 0);
		send(REQ_LOAD, 5, -7, 40'haa, 64'hfedcba9876543210, 0, 0);
		ask_build();
		ask_cell(0, 0);
		ask_cell(1, 2);
		ask_cell(2, 3);
		ask_cell(3, 0);
		ask_cell(63, 63);
		put_record(1, 1);
		ask_cell(0, 3);
		ask_build();
		ask_cell(3, 3);
		wipe_all();
		ask_cell(0, 0);
		put_record(1, 0);
		put_record(2, 0);
		put_record(3, 0);
		ask_build();
		ask_cell(0, 2);
		wipe_all();

		sent = 27;
		for (int s = 0; sent < 900; s++) begin
			jitter = $urandom_range(0, 3) != 0;
			if (sent > 780)
				calm = 1;
			if (s == 4) begin
				// 64 distinct categories on both maps
				wipe_all();
				for (int i = 0; i < 2 * MAX_CATS; i++)
					put_record(i % MAX_CATS - 20, (i * 7) % MAX_CATS * 3 - 90);
				ask_build();
				random_reads(10);
				ask_cell(63, 63);
				ask_cell(0, 63);
				ask_cell(63, 0);
				sent += 2 * MAX_CATS + 15;
			end else if (s == 9) begin
				// one map with too many categories
				wipe_all();
				for (int i = 0; i < MAX_CATS + 6; i++)
					put_record(i * 1000003 - 7, $urandom_range(0, 3));
				ask_build();
				random_reads(4);
				sent += MAX_CATS + 12;
			end else begin
				if (s == 12)
					want_choke = 1;
				spread = $urandom_range(2, 24);
				if ($urandom_range(0, 9) < 7) begin
					wipe_all();
					sent++;
				end
				n = $urandom_range(0, 20);
				for (int i = 0; i < n; i++)
					put_record(pick_cat(spread), pick_cat($urandom_range(2, 24)));
				sent += n;
				if ($urandom_range(0, 4) == 0) begin
					random_reads(2);
					sent += 2;
				end
				ask_build();
				n = $urandom_range(10, 30);
				random_reads(n);
				sent += n + 1;
				if ($urandom_range(0, 3) == 0) begin
					put_record(pick_cat(spread), pick_cat(spread));
					random_reads(5);
					ask_build();
					random_reads(5);
					sent += 12;
				end
				if ($urandom_range(0, 4) == 0) begin
					send(2'($urandom), pick_cat(spread), pick_cat(spread), 40'(rnd64()),
						rnd64(), 6'($urandom), 6'($urandom));
					sent++;
				end
			end
		end
		in_valid <= 1'b0;
		@(posedge clk);

		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
